@@ design/reverb_slot_crossfade_macros.svh @@
// assertion macros used by the reverb slot crossfade port-level checker
// expects clk and arst_n in the scope of use
`ifndef REVERB_SLOT_CROSSFADE_MACROS_SVH
`define REVERB_SLOT_CROSSFADE_MACROS_SVH

// consequent checked in the same cycle
`define RSX_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define RSX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rsx_pkg.sv @@
// types and constants of the reverb slot crossfade
// no dependencies
package rsx_pkg;

	localparam int GAIN_W    = 16;
	localparam int TIME_W    = 20;
	localparam int ROOM_W    = 6;
	localparam int NUM_W     = GAIN_W + TIME_W;
	localparam int DIV_STEPS = GAIN_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [1:0]        SLOTS_RESET = 2'd2;
	localparam logic [GAIN_W-1:0] MIX_RESET   = 16'd24904;
	localparam logic [TIME_W-1:0] FADE_RESET  = 20'd250000;

	typedef enum logic [1:0] {
		REG_SLOT_COUNT     = 2'd0,
		REG_REVERB_DISABLE = 2'd1,
		REG_MIX_LEVEL      = 2'd2,
		REG_FADE_TIME      = 2'd3
	} rsx_reg_t;

	typedef struct packed {
		logic [ROOM_W-1:0] room_id;
		logic [TIME_W-1:0] frame_time;
	} rsx_in_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_slot_a;
		logic [GAIN_W-1:0] gain_slot_b;
		logic              active_slot;
		logic [ROOM_W-1:0] preset_index;
		logic              preset_load;
	} rsx_out_t;

	typedef struct packed {
		rsx_reg_t          index;
		logic [TIME_W-1:0] value;
	} rsx_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_A,
		ST_MUL_B,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} rsx_state_t;

	typedef struct packed {
		logic start;
		logic prep;
		logic mul_a;
		logic mul_b;
		logic div_step;
		logic fin;
		logic out_load;
		logic slot;
	} rsx_cmd_t;

	typedef struct packed {
		logic two_slot;
		logic need_div;
		logic out_free;
	} rsx_stat_t;

endpackage

@@ design/rsx_chan_if.sv @@
// valid/ready channel carrying one payload item
// payload type set per instance
interface rsx_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/reverb_slot_crossfade.sv @@
// Reverb preset selection with a two-slot linear gain crossfade. One item is one frame tick;
// each item gives one result with both slot gains, the active slot and the chosen preset.
// An item goes from accept straight to the result step when one or no slot is in use, and
// through a setup step per slot when both slots are in use and no fade needs an
// interpolated gain. A slot that is mid-fade passes through a setup step, two passes through
// the single 16x20 multiplier, the 16-step restoring divider (one quotient bit per cycle)
// and a write-back. Slots are handled in turn, and a new item is taken the cycle after the
// result is loaded. The result sits in an output register, so the next item is taken while
// it waits. Configuration writes are always ready and must only be issued while the block
// is idle.
module reverb_slot_crossfade import rsx_pkg::*; #(
	parameter int ROOM_COUNT = 29
) (
	input logic        clk,
	input logic        arst_n,
	rsx_chan_if.sink   in,
	rsx_chan_if.source out,
	rsx_chan_if.sink   cfg
);

	rsx_cmd_t  cmd;
	rsx_stat_t stat;

	assign cfg.ready = 1'b1;

	rsx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rsx_dp #(
		.ROOM_COUNT (ROOM_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in.data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.out_ready (out.ready),
		.out_valid (out.valid),
		.out_data  (out.data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ design/rsx_ctrl.sv @@
// sequencer of the reverb slot crossfade: item accept, per-slot fade steps, result hand-off
// depends on rsx_pkg
module rsx_ctrl import rsx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rsx_stat_t stat,
	output rsx_cmd_t  cmd
);

	rsx_state_t       state_q, state_d;
	logic             slot_q, slot_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		slot_d   = slot_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.slot = slot_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					slot_d    = 1'b0;
					state_d   = stat.two_slot ? ST_PREP : ST_DONE;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (stat.need_div) begin
					state_d = ST_MUL_A;
				end else if (!slot_q) begin
					slot_d = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_d   = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_b = 1'b1;
				cnt_d     = '0;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				if (!slot_q) begin
					slot_d  = 1'b1;
					state_d = ST_PREP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ design/rsx_dp.sv @@
// datapath of the reverb slot crossfade: registers, slot faders, shared multiplier and divider
// depends on rsx_pkg
module rsx_dp import rsx_pkg::*; #(
	parameter int ROOM_COUNT = 29
) (
	input  logic      clk,
	input  logic      arst_n,
	input  rsx_in_t   in_data,
	input  logic      cfg_valid,
	input  rsx_cfg_t  cfg_data,
	input  logic      out_ready,
	output logic      out_valid,
	output rsx_out_t  out_data,
	input  rsx_cmd_t  cmd,
	output rsx_stat_t stat
);

	localparam int RC_W = ROOM_W + 1;

	// configuration
	logic [1:0]        slot_count_q;
	logic              reverb_disable_q;
	logic [GAIN_W-1:0] mix_level_q;
	logic [TIME_W-1:0] fade_time_q;

	// slot state
	logic [GAIN_W-1:0] gain_q [2];
	logic [GAIN_W-1:0] start_q [2];
	logic [GAIN_W-1:0] last_tgt_q [2];
	logic [TIME_W-1:0] elapsed_q [2];
	logic              cur_q;
	logic [ROOM_W-1:0] last_room_q;

	// item and arithmetic
	logic [TIME_W-1:0] ft_q;
	logic [ROOM_W-1:0] preset_q;
	logic              load_q;
	logic [NUM_W-1:0]  acc_q;
	logic [TIME_W-1:0] rem_q;
	logic [GAIN_W-1:0] quo_q;
	logic              out_valid_q;
	rsx_out_t          out_q;

	logic              room_ok;
	logic              room_chg;
	logic [GAIN_W-1:0] tgt;
	logic              tgt_chg;
	logic [TIME_W-1:0] el_eff;
	logic [TIME_W:0]   e_sum;
	logic              reach;
	logic [GAIN_W-1:0] mul_x;
	logic [TIME_W-1:0] mul_y;
	logic [NUM_W-1:0]  prod;
	logic [NUM_W-1:0]  sum_b;
	logic [TIME_W:0]   div_r;
	logic              div_ge;
	logic [TIME_W:0]   div_n;

	assign room_ok = (in_data.room_id != '0)
		&& ({1'b0, in_data.room_id} < RC_W'(ROOM_COUNT)) && !reverb_disable_q;
	assign room_chg = in_data.room_id != last_room_q;

	// active slot aims at mix level, the other at zero
	assign tgt     = (cmd.slot == cur_q) ? mix_level_q : '0;
	assign tgt_chg = last_tgt_q[cmd.slot] != tgt;
	assign el_eff  = tgt_chg ? '0 : elapsed_q[cmd.slot];
	assign e_sum   = {1'b0, el_eff} + {1'b0, ft_q};
	assign reach   = e_sum >= {1'b0, fade_time_q};

	assign mul_x = cmd.mul_b ? tgt : start_q[cmd.slot];
	assign mul_y = cmd.mul_b ? elapsed_q[cmd.slot] : fade_time_q - elapsed_q[cmd.slot];
	assign prod  = NUM_W'(mul_x) * NUM_W'(mul_y);
	assign sum_b = acc_q + prod;

	// restoring divide, one quotient bit per cycle
	assign div_r  = {rem_q, quo_q[GAIN_W-1]};
	assign div_ge = div_r >= {1'b0, fade_time_q};
	assign div_n  = div_ge ? div_r - {1'b0, fade_time_q} : div_r;

	assign stat.two_slot = slot_count_q[1];
	assign stat.need_div = (ft_q != '0) && !reach;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q     <= SLOTS_RESET;
			reverb_disable_q <= 1'b0;
			mix_level_q      <= MIX_RESET;
			fade_time_q      <= FADE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_data.index)
				REG_SLOT_COUNT:     slot_count_q     <= cfg_data.value[1:0];
				REG_REVERB_DISABLE: reverb_disable_q <= cfg_data.value[0];
				REG_MIX_LEVEL:      mix_level_q      <= cfg_data.value[GAIN_W-1:0];
				REG_FADE_TIME:      fade_time_q      <= cfg_data.value;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0]     <= MIX_RESET;
			gain_q[1]     <= '0;
			start_q[0]    <= MIX_RESET;
			start_q[1]    <= '0;
			last_tgt_q[0] <= MIX_RESET;
			last_tgt_q[1] <= '0;
			elapsed_q[0]  <= '0;
			elapsed_q[1]  <= '0;
			cur_q         <= 1'b0;
			last_room_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.start && slot_count_q[1] && room_chg) begin
				cur_q       <= !cur_q;
				last_room_q <= in_data.room_id;
			end
			if (cmd.prep) begin
				if (tgt_chg) begin
					last_tgt_q[cmd.slot] <= tgt;
					start_q[cmd.slot]    <= gain_q[cmd.slot];
				end
				if (ft_q == '0) begin
					elapsed_q[cmd.slot] <= el_eff;
				end else if (reach) begin
					elapsed_q[cmd.slot] <= fade_time_q;
					gain_q[cmd.slot]    <= tgt;
				end else begin
					elapsed_q[cmd.slot] <= e_sum[TIME_W-1:0];
				end
			end
			if (cmd.fin) gain_q[cmd.slot] <= quo_q;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ft_q     <= in_data.frame_time;
			preset_q <= room_ok ? in_data.room_id : '0;
			load_q   <= slot_count_q[1] ? room_chg : (slot_count_q == 2'd1);
		end
		if (cmd.mul_a) acc_q <= prod + NUM_W'(fade_time_q >> 1);
		if (cmd.mul_b) begin
			rem_q <= sum_b[NUM_W-1:GAIN_W];
			quo_q <= sum_b[GAIN_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= div_n[TIME_W-1:0];
			quo_q <= {quo_q[GAIN_W-2:0], div_ge};
		end
		if (cmd.out_load) begin
			out_q.gain_slot_a  <= gain_q[0];
			out_q.gain_slot_b  <= gain_q[1];
			out_q.active_slot  <= cur_q;
			out_q.preset_index <= preset_q;
			out_q.preset_load  <= load_q;
		end
	end

endmodule

@@ design/rsx_checker.sv @@
// port-level checks of the reverb slot crossfade, bound to the top level
// depends on rsx_pkg and reverb_slot_crossfade_macros.svh
`include "reverb_slot_crossfade_macros.svh"

module rsx_checker import rsx_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input rsx_out_t out_data
);

	// one item in flight
	`RSX_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted while busy")

	// no result rises in the cycle right after an accept
	`RSX_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result too early")

	// a new result means the sequencer is free again
	`RSX_ASSERT_SAME(a_ready_with_result, $rose(out_valid), in_ready, "not ready after result")

	// stalled result holds
	`RSX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind reverb_slot_crossfade rsx_checker u_rsx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in.valid),
	.in_ready  (in.ready),
	.out_valid (out.valid),
	.out_ready (out.ready),
	.out_data  (out.data)
);

@@ tb/sv/reverb_slot_crossfade_checker.sv @@
// frame result checker for the reverb slot crossfade: follows register writes and accepted
// ticks, predicts slot gains, active slot and preset, and compares each result in order
// depends on rsx_pkg
module reverb_slot_crossfade_checker import rsx_pkg::*; #(
	parameter int ROOM_COUNT = 29
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  rsx_in_t  in_data,
	input  logic     out_valid,
	input  logic     out_ready,
	input  rsx_out_t out_data,
	input  logic     cfg_valid,
	input  logic     cfg_ready,
	input  rsx_cfg_t cfg_data,
	output int       pending,
	output int       fail_count
);

	logic [1:0]        slots;
	logic              rev_off;
	logic [GAIN_W-1:0] mix;
	logic [TIME_W-1:0] fade;

	logic [GAIN_W-1:0] gain [2];
	logic [GAIN_W-1:0] gain_from [2];
	logic [GAIN_W-1:0] gain_goal [2];
	logic [TIME_W-1:0] elapsed [2];
	logic              cur_slot;
	logic [ROOM_W-1:0] prev_room;

	rsx_out_t frame_q[$];
	int       fails = 0;

	assign fail_count = fails;

	task automatic ramp_slot(input logic s, input logic [GAIN_W-1:0] goal,
			input logic [TIME_W-1:0] ft);
		logic [TIME_W:0] e;
		logic [63:0]     num;
		if (gain_goal[s] != goal) begin
			elapsed[s]   = '0;
			gain_from[s] = gain[s];
			gain_goal[s] = goal;
		end
		if (ft == '0)
			return;
		e = {1'b0, elapsed[s]} + {1'b0, ft};
		if (e >= {1'b0, fade}) begin
			elapsed[s] = fade;
			gain[s]    = goal;
		end else begin
			elapsed[s] = e[TIME_W-1:0];
			num = 64'(gain_from[s]) * 64'({1'b0, fade} - e) + 64'(goal) * 64'(e)
				+ 64'(fade >> 1);
			gain[s] = GAIN_W'(num / 64'(fade));
		end
	endtask

	task automatic predict_frame(input rsx_in_t tick, output rsx_out_t res);
		logic [ROOM_W-1:0] preset;
		logic              load;
		preset = '0;
		load   = 1'b0;
		if (tick.room_id != '0 && int'(tick.room_id) < ROOM_COUNT && !rev_off)
			preset = tick.room_id;
		if (slots >= 2'd2) begin
			if (tick.room_id == prev_room) begin
				ramp_slot(cur_slot, mix, tick.frame_time);
				ramp_slot(!cur_slot, '0, tick.frame_time);
			end else begin
				prev_room = tick.room_id;
				ramp_slot(cur_slot, '0, tick.frame_time);
				cur_slot = !cur_slot;
				ramp_slot(cur_slot, mix, tick.frame_time);
				load = 1'b1;
			end
		end else if (slots == 2'd1) begin
			load = 1'b1;
		end
		res.gain_slot_a  = gain[0];
		res.gain_slot_b  = gain[1];
		res.active_slot  = cur_slot;
		res.preset_index = preset;
		res.preset_load  = load;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsx_out_t want;
		if (!arst_n) begin
			slots        = SLOTS_RESET;
			rev_off      = 1'b0;
			mix          = MIX_RESET;
			fade         = FADE_RESET;
			gain[0]      = MIX_RESET;
			gain[1]      = '0;
			gain_from[0] = MIX_RESET;
			gain_from[1] = '0;
			gain_goal[0] = MIX_RESET;
			gain_goal[1] = '0;
			elapsed[0]   = '0;
			elapsed[1]   = '0;
			cur_slot     = 1'b0;
			prev_room    = '0;
			frame_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (frame_q.size() == 0) begin
					$error("frame result with no prediction waiting");
					fails++;
				end else begin
					want = frame_q.pop_front();
					check_field("gain_slot_a", want.gain_slot_a, out_data.gain_slot_a);
					check_field("gain_slot_b", want.gain_slot_b, out_data.gain_slot_b);
					check_field("active_slot", want.active_slot, out_data.active_slot);
					check_field("preset_index", want.preset_index, out_data.preset_index);
					check_field("preset_load", want.preset_load, out_data.preset_load);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_SLOT_COUNT:     slots   = cfg_data.value[1:0];
					REG_REVERB_DISABLE: rev_off = cfg_data.value[0];
					REG_MIX_LEVEL:      mix     = cfg_data.value[GAIN_W-1:0];
					REG_FADE_TIME:      fade    = cfg_data.value;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predict_frame(in_data, want);
				frame_q.push_back(want);
			end
			pending <= frame_q.size();
		end
	end

endmodule

@@ tb/sv/reverb_slot_crossfade_tb.sv @@
// top of the reverb slot crossfade testbench: clock, reset, frame ticks, register writes,
// random stalls on both channels and the verdict; checking is done by the checker module
// depends on rsx_pkg, rsx_chan_if, reverb_slot_crossfade and reverb_slot_crossfade_checker
module reverb_slot_crossfade_tb;
	import rsx_pkg::*;

	localparam int ROOMS       = 29;
	localparam int WATCH_LIMIT = 4000;
	localparam int LONG_HOLD   = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int pending;
	int fail_count;
	int sent        = 0;
	int taken       = 0;
	int idle_cycles = 0;

	logic [ROOM_W-1:0] last_sent_room = '0;
	logic [TIME_W-1:0] cur_fade       = FADE_RESET;

	rsx_chan_if #(.payload_t(rsx_in_t))  in_ch ();
	rsx_chan_if #(.payload_t(rsx_out_t)) out_ch ();
	rsx_chan_if #(.payload_t(rsx_cfg_t)) cfg_ch ();

	reverb_slot_crossfade #(.ROOM_COUNT(ROOMS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch),
		.cfg    (cfg_ch)
	);

	reverb_slot_crossfade_checker #(.ROOM_COUNT(ROOMS)) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_data    (in_ch.data),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_data   (out_ch.data),
		.cfg_valid  (cfg_ch.valid),
		.cfg_ready  (cfg_ch.ready),
		.cfg_data   (cfg_ch.data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #6 clk = ~clk;

	task automatic send_tick(input rsx_in_t item);
		int gap;
		gap = ((sent / 50) % 3 == 1) ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= item;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
		last_sent_room = item.room_id;
	endtask

	task automatic tick(input int room, input int ft);
		rsx_in_t item;
		item.room_id    = ROOM_W'(room);
		item.frame_time = TIME_W'(ft);
		send_tick(item);
	endtask

	task automatic write_reg(input rsx_reg_t idx, input logic [TIME_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{index: idx, value: val};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [1:0] slots, input logic rev_off,
			input logic [GAIN_W-1:0] mix, input logic [TIME_W-1:0] fade);
		write_reg(REG_SLOT_COUNT, TIME_W'(slots));
		write_reg(REG_REVERB_DISABLE, TIME_W'(rev_off));
		write_reg(REG_MIX_LEVEL, TIME_W'(mix));
		write_reg(REG_FADE_TIME, fade);
		cfg_ch.valid <= 1'b0;
		cur_fade = fade;
	endtask

	// wait until every predicted frame result has been taken
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic rsx_in_t rand_tick(input logic [ROOM_W-1:0] prev,
			input logic [TIME_W-1:0] fd);
		rsx_in_t t;
		int      pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			t.room_id = prev;
		else if (pick < 90)
			t.room_id = ROOM_W'($urandom_range(0, 7));
		else
			t.room_id = ROOM_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 15)
			t.frame_time = '0;
		else if (pick < 55)
			t.frame_time = TIME_W'($urandom_range(1, int'(fd >> 3) + 1));
		else if (pick < 85)
			t.frame_time = TIME_W'($urandom);
		else begin
			case ($urandom_range(0, 3))
				0:       t.frame_time = TIME_W'(1);
				1:       t.frame_time = '1;
				2:       t.frame_time = fd - 1'b1;
				default: t.frame_time = fd;
			endcase
		end
		return t;
	endfunction

	task automatic run_phase(input logic [1:0] slots, input logic rev_off,
			input logic [GAIN_W-1:0] mix, input logic [TIME_W-1:0] fade, input int count);
		drain();
		apply_settings(slots, rev_off, mix, fade);
		repeat (count) send_tick(rand_tick(last_sent_room, cur_fade));
	endtask

	initial begin
		in_ch.valid  <= 1'b0;
		in_ch.data   <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: hold, room switches, preset range edges, clamp
		tick(0, 0);
		tick(5, 1000);
		tick(5, 0);
		tick(5, 1048575);
		tick(63, 0);
		tick(63, 20000);
		tick(28, 100000);
		tick(28, 1);
		tick(29, 50000);
		tick(1, 249999);
		tick(1, 1);
		tick(0, 1048575);

		// fade time lowered while both slots are mid-fade
		drain();
		apply_settings(2'd2, 1'b0, 16'hFFFF, 20'd1000000);
		tick(7, 300000);
		tick(7, 300000);
		drain();
		apply_settings(2'd2, 1'b0, 16'hFFFF, 20'd1000);
		tick(7, 5);
		tick(7, 0);
		tick(9, 0);

		run_phase(2'd2, 1'b0, 16'hFFFF, 20'hFFFFF, 150);
		run_phase(2'd2, 1'b1, 16'd0, 20'd1, 90);
		run_phase(2'd1, 1'b0, 16'd40000, 20'd5000, 80);
		run_phase(2'd0, 1'b1, 16'd12345, 20'd5000, 60);
		run_phase(2'd3, 1'b0, 16'd30000, 20'd2000, 150);
		run_phase(2'd2, 1'b0, 16'd50000, 20'd0, 60);
		run_phase(2'd2, 1'b0, 16'd20000, 20'd800000, 120);
		run_phase(2'd2, 1'b0, 16'd50000, 20'd100, 40);
		run_phase(2'd2, 1'b0, MIX_RESET, FADE_RESET, 130);

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// long hold-offs let the block fill up and stall its input
			if (taken == 60 || taken == 500)
				stall = LONG_HOLD;
			else if ((taken / 40) % 3 == 2)
				stall = 0;
			else
				stall = $urandom_range(0, 16);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			taken++;
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCH_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
